// ----- rtl/core/spf_pkg.sv -----
// Shared constants, command and status types for the smallest-factor factorizer.
package spf_pkg;

    localparam int TABLE_SIZE = 262144;
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int VW = 18;
    localparam int EW = 5;
    localparam int KW = $clog2(VW);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_SQ,
        OP_RD_I,
        OP_J_START,
        OP_RD_J,
        OP_WR_J,
        OP_I_NEXT,
        OP_LOAD,
        OP_RD_R,
        OP_P_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_TAKE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic sq_over;
        logic i_prime;
        logic j_end;
        logic in_small;
        logic div_last;
        logic div_exact;
        logic r_done;
    } t_sts;

endpackage

// ----- rtl/core/spf_datapath.sv -----
// Datapath: factor table memory, sieve counters, remaining value and restoring divider.
module spf_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spf_pkg::t_cmd        i_cmd,
    input  logic [17:0]          i_value,
    output spf_pkg::t_sts        o_sts,
    output logic [17:0]          o_prime,
    output logic [4:0]           o_exponent,
    output logic                 o_last
);
    import spf_pkg::*;

    logic [AW-1:0]   r_mem [TABLE_SIZE];
    logic [AW-1:0]   r_rdata;
    logic [AW-1:0]   rd_addr;
    logic [AW:0]     r_a;
    logic [AW-1:0]   r_i;
    logic [2*AW-1:0] r_sq;
    logic [AW:0]     r_j;
    logic [VW-1:0]   r_r;
    logic [VW-1:0]   r_p;
    logic [EW-1:0]   r_cnt;
    logic [VW-1:0]   r_quo;
    logic [VW:0]     r_rem;
    logic [KW-1:0]   r_k;
    logic [VW:0]     rem_sh;
    logic [VW:0]     rem_sub;
    logic            in_range;
    logic [VW-1:0]   r_o_prime;
    logic [EW-1:0]   r_o_exp;
    logic            r_o_last;

    assign in_range = (32'(i_value) < 32'(TABLE_SIZE));
    assign rem_sh   = {r_rem[VW-1:0], r_quo[VW-1]};
    assign rem_sub  = rem_sh - {1'b0, r_p};

    always_comb begin
        unique case (i_cmd.op)
            OP_RD_I: rd_addr = r_i;
            OP_RD_J: rd_addr = r_j[AW-1:0];
            default: rd_addr = AW'(r_r);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (i_cmd.op == OP_INIT) begin
            r_mem[r_a[AW-1:0]] <= r_a[AW-1:0];
        end else if (i_cmd.op == OP_WR_J && r_rdata == r_j[AW-1:0]) begin
            r_mem[r_j[AW-1:0]] <= r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else if (i_cmd.op == OP_INIT) begin
            r_a <= r_a + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_INIT:      r_i <= AW'(2);
            OP_SQ:        r_sq <= r_i * r_i;
            OP_J_START:   r_j <= r_sq[AW:0];
            OP_WR_J:      r_j <= r_j + {1'b0, r_i};
            OP_I_NEXT:    r_i <= r_i + 1'b1;
            OP_LOAD: begin
                r_r   <= (in_range && i_value > VW'(1)) ? i_value : '0;
                r_p   <= '0;
                r_cnt <= '0;
            end
            OP_P_LOAD: begin
                r_p   <= VW'(r_rdata);
                r_cnt <= '0;
            end
            OP_DIV_START: begin
                r_quo <= r_r;
                r_rem <= '0;
                r_k   <= '0;
            end
            OP_DIV_STEP: begin
                r_k <= r_k + 1'b1;
                if (!rem_sub[VW]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[VW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[VW-2:0], 1'b0};
                end
            end
            OP_DIV_TAKE: begin
                r_r   <= r_quo;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_EMIT: begin
                r_o_prime <= r_p;
                r_o_exp   <= r_cnt;
                r_o_last  <= (r_r < VW'(2));
            end
            default: ;
        endcase
    end

    assign o_sts.init_last = (r_a == (AW+1)'(TABLE_SIZE - 1));
    assign o_sts.sq_over   = (r_sq >= (2*AW)'(TABLE_SIZE));
    assign o_sts.i_prime   = (r_rdata == r_i);
    assign o_sts.j_end     = (r_j >= (AW+1)'(TABLE_SIZE));
    assign o_sts.in_small  = !(in_range && i_value > VW'(1));
    assign o_sts.div_last  = (r_k == KW'(VW - 1));
    assign o_sts.div_exact = (r_rem == '0);
    assign o_sts.r_done    = (r_r < VW'(2));

    assign o_prime    = r_o_prime;
    assign o_exponent = r_o_exp;
    assign o_last     = r_o_last;

endmodule

// ----- rtl/core/spf_ctrl.sv -----
// Controller: sieve sequencing, factorization loop and output beat handshake.
module spf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  spf_pkg::t_sts  i_sts,
    output spf_pkg::t_cmd  o_cmd
);
    import spf_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_SQ, S_SQCHK, S_ICHK, S_JRD, S_JWR,
        S_IDLE, S_RDR, S_P, S_DSTART, S_DSTEP, S_DCHK, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_o_valid, n_o_valid;
    logic   out_free;

    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        n_o_valid = r_o_valid && i_stall;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_INIT;
                if (i_sts.init_last) n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_SQCHK;
            end
            S_SQCHK: begin
                if (i_sts.sq_over) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_I;
                    n_state  = S_ICHK;
                end
            end
            S_ICHK: begin
                if (i_sts.i_prime) begin
                    o_cmd.op = OP_J_START;
                    n_state  = S_JRD;
                end else begin
                    o_cmd.op = OP_I_NEXT;
                    n_state  = S_SQ;
                end
            end
            S_JRD: begin
                if (i_sts.j_end) begin
                    o_cmd.op = OP_I_NEXT;
                    n_state  = S_SQ;
                end else begin
                    o_cmd.op = OP_RD_J;
                    n_state  = S_JWR;
                end
            end
            S_JWR: begin
                o_cmd.op = OP_WR_J;
                n_state  = S_JRD;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_sts.in_small ? S_EMIT : S_RDR;
                end
            end
            S_RDR: begin
                o_cmd.op = OP_RD_R;
                n_state  = S_P;
            end
            S_P: begin
                o_cmd.op = OP_P_LOAD;
                n_state  = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_sts.div_last) n_state = S_DCHK;
            end
            S_DCHK: begin
                if (i_sts.div_exact) begin
                    o_cmd.op = OP_DIV_TAKE;
                    n_state  = S_DSTART;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.op  = OP_EMIT;
                    n_o_valid = 1'b1;
                    n_state   = i_sts.r_done ? S_IDLE : S_RDR;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

endmodule

// ----- rtl/core/smallest_factor_factorizer.sv -----
// Top level of the smallest-factor factorizer: controller plus datapath.
// After reset the block writes every table entry with its own index and then runs
// the sieve, holding o_stall high until done. Each input beat is then broken into
// (prime, exponent) result beats in rising prime order, o_last on the final one;
// inputs 0, 1 or beyond the table give one beat with prime 0. The time taken per
// distinct prime is set by the one-bit-per-cycle restoring divider that is reused
// for every trial division; results wait in an output register.
module smallest_factor_factorizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [17:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [17:0] o_prime,
    output logic [4:0]  o_exponent,
    output logic        o_last
);
    import spf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    spf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_value),
        .o_sts      (sts),
        .o_prime    (o_prime),
        .o_exponent (o_exponent),
        .o_last     (o_last)
    );

endmodule
